FILE: sv/ptt_pkg.sv
// Shared types and codes of the periodic timer table.
package ptt_pkg;

  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_CREATE  = 2'd1;
  localparam logic [1:0] OP_DESTROY = 2'd2;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_FIRED  = 2'd1;
  localparam logic [1:0] KIND_NONE   = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_ZERO_PER  = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  // Cell commands.
  localparam logic [1:0] CELL_HOLD  = 2'd0;
  localparam logic [1:0] CELL_SHIFT = 2'd1;
  localparam logic [1:0] CELL_DROP  = 2'd2;
  localparam logic [1:0] CELL_LOAD  = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] timer_id;
    logic [15:0] period;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [31:0] fired_id;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] period;
    logic [31:0] due;
  } entry_t;

  typedef struct packed {
    logic [1:0] cmd;
    entry_t     fb;
  } cell_ctrl_t;

endpackage

FILE: sv/ptt_cell.sv
// One timer cell of the rotating entry chain.
module ptt_cell #(
  parameter int IDX_W    = 4,
  parameter int CELL_IDX = 0
) (
  input  logic                clk_i,
  input  ptt_pkg::cell_ctrl_t ctrl_i,
  input  logic [IDX_W-1:0]    pos_i,
  input  ptt_pkg::entry_t     right_i,
  output ptt_pkg::entry_t     entry_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

  ptt_pkg::entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.cmd)
      ptt_pkg::CELL_SHIFT: begin
        if (MyIdx < pos_i) begin
          entry_d = right_i;
        end else if (MyIdx == pos_i) begin
          entry_d = ctrl_i.fb;
        end
      end
      ptt_pkg::CELL_DROP: begin
        if (MyIdx < pos_i) begin
          entry_d = right_i;
        end
      end
      ptt_pkg::CELL_LOAD: begin
        if (MyIdx == pos_i) begin
          entry_d = ctrl_i.fb;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: sv/periodic_timer_table_unit.sv
// Top level of the periodic timer table: controller and chain of timer cells.
//
//  channel | direction | handshake               | payload
//  command | in        | start high, busy low    | cmd_i  (ptt_pkg::cmd_t)
//  result  | out       | res_valid_o, one cycle  | res_o  (ptt_pkg::res_t)
//
// A create gives its status in the cycle after acceptance; an unused op gives nothing.
// A destroy and a tick each make one lap over the N timers held (N being the timer count),
// because the entries rotate through the cell chain one position per cycle.
// Fired results of a tick come at most one per cycle, the final one marked last.
// Reset clears the tick counter, the timer count and the controller; cells are not reset.
// Results cannot be stalled; busy stays high until the last result of a transaction.
module periodic_timer_table_unit #(
  parameter int MAX_TIMERS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  ptt_pkg::cmd_t cmd_i,
  output logic          busy,
  output logic          res_valid_o,
  output ptt_pkg::res_t res_o
);

  localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CNT_W = $clog2(MAX_TIMERS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_TICK = 2'd1;
  localparam logic [1:0] ST_TEND = 2'd2;
  localparam logic [1:0] ST_DEL  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [31:0]      tick_q, tick_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic [CNT_W-1:0] len_q, len_d;
  logic             found_q, found_d;
  logic [31:0]      target_q, target_d;
  logic             pend_q, pend_d;
  logic [31:0]      pend_id_q, pend_id_d;
  logic             vld_q, vld_d;
  ptt_pkg::res_t    res_q, res_d;

  ptt_pkg::cell_ctrl_t ctrl;
  logic [IDX_W-1:0]    pos;
  ptt_pkg::entry_t     ent [MAX_TIMERS];
  ptt_pkg::entry_t     head;
  logic                accept;
  logic                lap_end;
  logic                fire;
  logic                match;

  for (genvar j = 0; j < MAX_TIMERS; j++) begin : g_cell
    ptt_pkg::entry_t right;
    if (j < MAX_TIMERS - 1) begin : g_mid
      assign right = ent[j+1];
    end else begin : g_end
      assign right = ctrl.fb;
    end
    ptt_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (j)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .pos_i   (pos),
      .right_i (right),
      .entry_o (ent[j])
    );
  end

  assign head    = ent[0];
  assign accept  = start && !busy;
  assign lap_end = (k_q == len_q - CNT_W'(1));
  assign fire    = (head.due == tick_q);
  assign match   = !found_q && (head.id == target_q);

  always_comb begin
    state_d   = state_q;
    tick_d    = tick_q;
    cnt_d     = cnt_q;
    k_d       = k_q;
    len_d     = len_q;
    found_d   = found_q;
    target_d  = target_q;
    pend_d    = pend_q;
    pend_id_d = pend_id_q;
    vld_d     = 1'b0;
    res_d     = res_q;
    ctrl.cmd  = ptt_pkg::CELL_HOLD;
    ctrl.fb   = head;
    pos       = IDX_W'(cnt_q - CNT_W'(1));
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_i.op)
            ptt_pkg::OP_TICK: begin
              tick_d = tick_q + 32'd1;
              k_d    = '0;
              len_d  = cnt_q;
              pend_d = 1'b0;
              state_d = (cnt_q == '0) ? ST_TEND : ST_TICK;
            end
            ptt_pkg::OP_CREATE: begin
              vld_d = 1'b1;
              res_d = '{kind: ptt_pkg::KIND_STATUS, status: ptt_pkg::STAT_OK,
                        fired_id: 32'd0, last: 1'b1};
              if (cmd_i.period == 16'd0) begin
                res_d.status = ptt_pkg::STAT_ZERO_PER;
              end else if (cnt_q == CNT_W'(MAX_TIMERS)) begin
                res_d.status = ptt_pkg::STAT_FULL;
              end else begin
                ctrl.cmd = ptt_pkg::CELL_LOAD;
                pos      = IDX_W'(cnt_q);
                ctrl.fb  = '{id: cmd_i.timer_id, period: cmd_i.period,
                             due: tick_q + {16'd0, cmd_i.period}};
                cnt_d    = cnt_q + CNT_W'(1);
              end
            end
            ptt_pkg::OP_DESTROY: begin
              if (cnt_q == '0) begin
                vld_d = 1'b1;
                res_d = '{kind: ptt_pkg::KIND_STATUS, status: ptt_pkg::STAT_NOT_FOUND,
                          fired_id: 32'd0, last: 1'b1};
              end else begin
                k_d      = '0;
                len_d    = cnt_q;
                found_d  = 1'b0;
                target_d = cmd_i.timer_id;
                state_d  = ST_DEL;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_TICK: begin
        ctrl.cmd = ptt_pkg::CELL_SHIFT;
        if (fire) begin
          ctrl.fb.due = head.due + {16'd0, head.period};
          if (pend_q) begin
            vld_d = 1'b1;
            res_d = '{kind: ptt_pkg::KIND_FIRED, status: ptt_pkg::STAT_OK,
                      fired_id: pend_id_q, last: 1'b0};
          end
          pend_d    = 1'b1;
          pend_id_d = head.id;
        end
        k_d = k_q + CNT_W'(1);
        if (lap_end) begin
          state_d = ST_TEND;
        end
      end
      ST_TEND: begin
        vld_d = 1'b1;
        if (pend_q) begin
          res_d = '{kind: ptt_pkg::KIND_FIRED, status: ptt_pkg::STAT_OK,
                    fired_id: pend_id_q, last: 1'b1};
        end else begin
          res_d = '{kind: ptt_pkg::KIND_NONE, status: ptt_pkg::STAT_OK,
                    fired_id: 32'd0, last: 1'b1};
        end
        pend_d  = 1'b0;
        state_d = ST_IDLE;
      end
      ST_DEL: begin
        if (match) begin
          ctrl.cmd = ptt_pkg::CELL_DROP;
          pos      = IDX_W'(MAX_TIMERS - 1);
          cnt_d    = cnt_q - CNT_W'(1);
          found_d  = 1'b1;
        end else begin
          ctrl.cmd = ptt_pkg::CELL_SHIFT;
        end
        k_d = k_q + CNT_W'(1);
        if (lap_end) begin
          vld_d = 1'b1;
          res_d = '{kind: ptt_pkg::KIND_STATUS,
                    status: (found_q || match) ? ptt_pkg::STAT_OK
                                               : ptt_pkg::STAT_NOT_FOUND,
                    fired_id: 32'd0, last: 1'b1};
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tick_q  <= '0;
      cnt_q   <= '0;
      k_q     <= '0;
      len_q   <= '0;
      found_q <= 1'b0;
      pend_q  <= 1'b0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      tick_q  <= tick_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      len_q   <= len_d;
      found_q <= found_d;
      pend_q  <= pend_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    target_q  <= target_d;
    pend_id_q <= pend_id_d;
    res_q     <= res_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = vld_q;
  assign res_o       = res_q;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_TIMERS))
    else $error("Timer count exceeds the table size.");

  a_lap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TICK || state_q == ST_DEL) |-> (k_q < len_q))
    else $error("Rotation step runs past the lap length.");

  a_more_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last) |-> busy)
    else $error("A non-final result was not followed by further work.");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind != ptt_pkg::KIND_FIRED) |-> res_o.last)
    else $error("A status or idle tick result was not marked last.");
`endif

endmodule
